FILE: sv/lprt_pkg.sv
// Package for the linear prefix route table.
// Holds the operation, status and write codes and the item types shared by the cells and the top.
// Depends on nothing.
package lprt_pkg;

	localparam int ADDR_W     = 32;
	localparam int PORT_W     = 4;
	localparam int PORT_COUNT = 16;
	localparam int IN_W       = 104;
	localparam int OUT_W      = 80;
	localparam int DEPTH_DEF  = 64;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NO_ROUTE  = 3'd1,
		STAT_EXISTS    = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_REPLACE,
		WR_INSERT,
		WR_REMOVE
	} wr_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DELIVER
	} state_t;

	// Search item handed from cell to cell.
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic              hit;
		logic [ADDR_W-1:0] best_mask;
		logic [ADDR_W-1:0] best_gw;
		logic [PORT_W-1:0] best_port;
		logic              same;
		logic [ADDR_W-1:0] same_gw;
		logic [PORT_W-1:0] same_port;
		logic              free;
	} token_t;

	// Table update broadcast to all cells; only the marked cell applies it.
	typedef struct packed {
		wr_kind_t          kind;
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
	} wr_cmd_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] next_hop;
		logic [PORT_W-1:0] route_port;
		logic [ADDR_W-1:0] prev_gw;
		logic [PORT_W-1:0] prev_port;
	} result_t;

endpackage

FILE: sv/linear_prefix_route_table.sv
// Linear prefix route table: lookup, add and remove over a chain of one cell per slot.
// An item passes all TABLE_DEPTH cells in turn; its result is registered in a pending register,
// then in the output register behind m_tvalid. One item is in flight at a time; the next is
// accepted once the result is in the output register, later while a result waits on m_tready.
// Reset clears all slot valid bits at once, so the table is empty and usable right after reset.
// Depends on lprt_pkg and lprt_cell.
module linear_prefix_route_table #(
	parameter int TABLE_DEPTH = lprt_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// mode[1:0], address[33:2], mask[65:34], gateway[97:66], egress_port[101:98],
	// replace_ok[102], zero fill[103]
	input  logic [lprt_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[2:0], next_hop[34:3], route_port[38:35], previous_gateway[70:39],
	// previous_port[74:71], zero fill[79:75]
	output logic [lprt_pkg::OUT_W-1:0] m_tdata
);
	import lprt_pkg::*;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
		logic              repl;
	} req_t;

	state_t  state_q, state_d;
	req_t    req_q;
	result_t pend_q, out_q, res_d;
	logic    m_tvalid_q;
	wr_cmd_t wr_d, wr;

	logic   chain_act [0:TABLE_DEPTH];
	token_t chain_tok [0:TABLE_DEPTH];

	logic              accept;
	logic              emerge;
	logic              load_out;
	logic [PORT_W-1:0] in_port;
	logic [PORT_W-1:0] clamped_port;
	token_t            last_tok;

	assign accept   = s_tvalid && s_tready;
	assign last_tok = chain_tok[TABLE_DEPTH];
	assign in_port  = s_tdata[101:98];

	always_comb begin
		if (32'(in_port) >= PORT_COUNT) begin
			clamped_port = PORT_W'(PORT_COUNT - 1);
		end else begin
			clamped_port = in_port;
		end
	end

	always_comb begin
		chain_act[0]           = accept;
		chain_tok[0]           = '0;
		chain_tok[0].address   = s_tdata[33:2];
		chain_tok[0].mask      = s_tdata[65:34];
		chain_tok[0].prefix    = s_tdata[33:2] & s_tdata[65:34];
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lprt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_act  (chain_act[i]),
			.in_tok  (chain_tok[i]),
			.wr      (wr),
			.out_act (chain_act[i+1]),
			.out_tok (chain_tok[i+1])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (chain_act[TABLE_DEPTH]) begin
					state_d = S_DELIVER;
				end
			end
			S_DELIVER: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		emerge   = (state_q == S_SEARCH) && chain_act[TABLE_DEPTH];
		load_out = (state_q == S_DELIVER) && (!m_tvalid_q || m_tready);
	end

	always_comb begin
		res_d        = '0;
		res_d.status = STAT_OK;
		wr_d         = '0;
		wr_d.kind    = WR_NONE;
		wr_d.prefix  = last_tok.prefix;
		wr_d.mask    = last_tok.mask;
		wr_d.gateway = req_q.gateway;
		wr_d.port    = req_q.port;
		unique case (op_t'(req_q.mode))
			OP_LOOKUP: begin
				if (last_tok.hit) begin
					res_d.next_hop   = (last_tok.best_gw != '0) ? last_tok.best_gw : req_q.address;
					res_d.route_port = last_tok.best_port;
				end else begin
					res_d.status = STAT_NO_ROUTE;
				end
			end
			OP_ADD: begin
				if (last_tok.same) begin
					res_d.prev_gw   = last_tok.same_gw;
					res_d.prev_port = last_tok.same_port;
					if (req_q.repl) begin
						wr_d.kind = WR_REPLACE;
					end else begin
						res_d.status = STAT_EXISTS;
					end
				end else if (last_tok.free) begin
					wr_d.kind = WR_INSERT;
				end else begin
					res_d.status = STAT_FULL;
				end
			end
			OP_REMOVE: begin
				if (last_tok.same) begin
					res_d.prev_gw   = last_tok.same_gw;
					res_d.prev_port = last_tok.same_port;
					wr_d.kind       = WR_REMOVE;
				end else begin
					res_d.status = STAT_NOT_FOUND;
				end
			end
			default: begin
				res_d.status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		wr = wr_d;
		if (!emerge) begin
			wr.kind = WR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.mode    <= s_tdata[1:0];
			req_q.address <= s_tdata[33:2];
			req_q.gateway <= s_tdata[97:66];
			req_q.port    <= clamped_port;
			req_q.repl    <= s_tdata[102];
		end
		if (emerge) begin
			pend_q <= res_d;
		end
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_q.prev_port, out_q.prev_gw, out_q.route_port,
		out_q.next_hop, out_q.status};

	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		chain_act[TABLE_DEPTH] |-> state_q == S_SEARCH)
		else $error("search item left the chain outside the search phase");

	a_inject: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> chain_act[1])
		else $error("accepted item did not enter the first cell");

	a_write_then_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.kind != WR_NONE) |=> state_q == S_DELIVER)
		else $error("table update issued outside the end of a search");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid)
		else $error("finished result was not presented");

endmodule

FILE: sv/lprt_cell.sv
// One route table slot with its stage of the search chain.
// Compares the passing item against its entry, remembers whether it is the target of a later
// update, and applies that update. Depends on lprt_pkg.
module lprt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_act,
	input  lprt_pkg::token_t in_tok,
	input  lprt_pkg::wr_cmd_t wr,
	output logic             out_act,
	output lprt_pkg::token_t out_tok
);
	import lprt_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] prefix_q;
	logic [ADDR_W-1:0] mask_q;
	logic [ADDR_W-1:0] gw_q;
	logic [PORT_W-1:0] port_q;
	logic              same_mark_q;
	logic              free_mark_q;
	logic              act_q;
	token_t            tok_q;

	logic   take;
	logic   same_here;
	logic   free_here;
	token_t tok_d;

	always_comb begin
		take      = valid_q && ((in_tok.address & mask_q) == prefix_q)
			&& (!in_tok.hit || (mask_q > in_tok.best_mask));
		same_here = valid_q && !in_tok.same && (mask_q == in_tok.mask)
			&& (prefix_q == in_tok.prefix);
		free_here = !valid_q && !in_tok.free;
		tok_d     = in_tok;
		if (take) begin
			tok_d.hit       = 1'b1;
			tok_d.best_mask = mask_q;
			tok_d.best_gw   = gw_q;
			tok_d.best_port = port_q;
		end
		if (same_here) begin
			tok_d.same      = 1'b1;
			tok_d.same_gw   = gw_q;
			tok_d.same_port = port_q;
		end
		if (free_here) begin
			tok_d.free = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			same_mark_q <= 1'b0;
			free_mark_q <= 1'b0;
			valid_q     <= 1'b0;
		end else begin
			act_q <= in_act;
			if (in_act) begin
				same_mark_q <= same_here;
				free_mark_q <= free_here;
			end
			if (wr.kind == WR_INSERT && free_mark_q) begin
				valid_q <= 1'b1;
			end else if (wr.kind == WR_REMOVE && same_mark_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (wr.kind == WR_INSERT && free_mark_q) begin
			prefix_q <= wr.prefix;
			mask_q   <= wr.mask;
			gw_q     <= wr.gateway;
			port_q   <= wr.port;
		end else if (wr.kind == WR_REPLACE && same_mark_q) begin
			gw_q   <= wr.gateway;
			port_q <= wr.port;
		end
	end

	assign out_act = act_q;
	assign out_tok = tok_q;

endmodule

FILE: tb/sv/tb_linear_prefix_route_table.sv
`timescale 1ns / 1ps
// Testbench for linear_prefix_route_table: directed and random lookup, add and remove items.
// Predicts every result with its own copy of the route slots and checks each result field.
// Depends on lprt_pkg and linear_prefix_route_table.
module tb_linear_prefix_route_table;
	import lprt_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int ITEM_TARGET    = 1450;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] egress_port;
		logic              replace_ok;
	} route_req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] next_hop;
		logic [PORT_W-1:0] route_port;
		logic [ADDR_W-1:0] prev_gw;
		logic [PORT_W-1:0] prev_port;
	} route_resp_t;

	typedef struct {
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
	} route_key_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;

	logic                slot_valid [DEPTH];
	logic [ADDR_W-1:0]   slot_prefix [DEPTH];
	logic [ADDR_W-1:0]   slot_mask [DEPTH];
	logic [ADDR_W-1:0]   slot_gw [DEPTH];
	logic [PORT_W-1:0]   slot_port [DEPTH];

	route_req_t          pending_reqs [$];
	route_resp_t         expected_resp [$];
	route_key_t          key_pool [$];
	logic [ADDR_W-1:0]   route_bases [8];
	route_req_t          cur_req;
	route_resp_t         want;
	logic                in_taken;
	logic                offer;
	logic                quiet;
	int                  items_taken;
	int                  results_seen;
	int                  fail_count;
	int                  idle_cycles;
	int                  hold_left;
	logic                hold_done;
	int                  status_count [5];

	linear_prefix_route_table #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	assign quiet = items_taken >= 700 && items_taken < 900;

	function automatic int find_route(logic [ADDR_W-1:0] prefix, logic [ADDR_W-1:0] mask);
		for (int i = 0; i < DEPTH; i++)
			if (slot_valid[i] && slot_mask[i] == mask && slot_prefix[i] == prefix)
				return i;
		return -1;
	endfunction

	function automatic route_resp_t route_table_step(route_req_t r);
		route_resp_t       o;
		logic [ADDR_W-1:0] pfx;
		logic [PORT_W-1:0] port;
		int                hit;
		o        = '0;
		o.status = STAT_OK;
		pfx      = r.address & r.mask;
		port     = r.egress_port;
		if (port >= PORT_COUNT)
			port = PORT_W'(PORT_COUNT - 1);
		case (r.mode)
			OP_LOOKUP: begin
				hit = -1;
				for (int i = 0; i < DEPTH; i++)
					if (slot_valid[i] && (r.address & slot_mask[i]) == slot_prefix[i])
						if (hit < 0 || slot_mask[i] > slot_mask[hit])
							hit = i;
				if (hit < 0) begin
					o.status = STAT_NO_ROUTE;
				end else begin
					o.next_hop   = slot_gw[hit] != '0 ? slot_gw[hit] : r.address;
					o.route_port = slot_port[hit];
				end
			end
			OP_ADD: begin
				hit = find_route(pfx, r.mask);
				if (hit >= 0) begin
					o.prev_gw   = slot_gw[hit];
					o.prev_port = slot_port[hit];
					if (!r.replace_ok) begin
						o.status = STAT_EXISTS;
					end else begin
						slot_gw[hit]   = r.gateway;
						slot_port[hit] = port;
					end
				end else begin
					hit = -1;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!slot_valid[i])
							hit = i;
					if (hit < 0) begin
						o.status = STAT_FULL;
					end else begin
						slot_valid[hit]  = 1'b1;
						slot_prefix[hit] = pfx;
						slot_mask[hit]   = r.mask;
						slot_gw[hit]     = r.gateway;
						slot_port[hit]   = port;
					end
				end
			end
			OP_REMOVE: begin
				hit = find_route(pfx, r.mask);
				if (hit < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					o.prev_gw        = slot_gw[hit];
					o.prev_port      = slot_port[hit];
					slot_valid[hit]  = 1'b0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic route_key_t new_key();
		route_key_t k;
		int         len;
		len = $urandom_range(0, 32);
		if ($urandom_range(0, 7) == 0)
			k.mask = $urandom;
		else if (len == 0)
			k.mask = '0;
		else
			k.mask = {ADDR_W{1'b1}} << (32 - len);
		k.prefix = ($urandom_range(0, 3) == 0 ? ADDR_W'($urandom)
			: route_bases[$urandom_range(0, 7)]) & k.mask;
		return k;
	endfunction

	function automatic route_req_t random_req();
		route_req_t r;
		r.mode        = OP_LOOKUP;
		r.address     = $urandom;
		r.mask        = $urandom;
		r.gateway     = $urandom_range(0, 3) == 0 ? '0 : ADDR_W'($urandom);
		r.egress_port = PORT_W'($urandom);
		r.replace_ok  = 1'($urandom);
		return r;
	endfunction

	task automatic push_req(logic [1:0] mode, logic [ADDR_W-1:0] address,
		logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] gateway, logic [PORT_W-1:0] port,
		logic replace_ok);
		route_req_t r;
		r.mode        = mode;
		r.address     = address;
		r.mask        = mask;
		r.gateway     = gateway;
		r.egress_port = port;
		r.replace_ok  = replace_ok;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic gen_mixed(int n);
		route_req_t r;
		route_key_t k;
		int         pick;
		int         sel;
		repeat (n) begin
			r    = random_req();
			pick = $urandom_range(0, 99);
			if (key_pool.size() > 48 && pick >= 45 && pick < 75)
				pick = 80;
			if (pick < 45) begin
				if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
					k         = key_pool[$urandom_range(0, key_pool.size() - 1)];
					r.address = k.prefix | ($urandom & ~k.mask);
				end
			end else if (pick < 75) begin
				r.mode = OP_ADD;
				if (key_pool.size() > 0 && $urandom_range(0, 2) == 0) begin
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				end else begin
					k = new_key();
					if (key_pool.size() < DEPTH)
						key_pool.insert(key_pool.size(), k);
				end
				r.mask    = k.mask;
				r.address = k.prefix | ($urandom_range(0, 1) ? ($urandom & ~k.mask) : '0);
			end else if (pick < 95) begin
				r.mode = OP_REMOVE;
				if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
					sel = $urandom_range(0, key_pool.size() - 1);
					k   = key_pool[sel];
					key_pool.delete(sel);
					r.mask    = k.mask;
					r.address = k.prefix | ($urandom & ~k.mask);
				end
			end else begin
				r.mode = OP_UNUSED;
			end
			pending_reqs.insert(pending_reqs.size(), r);
		end
	endtask

	task automatic gen_fill(int n);
		route_req_t r;
		route_key_t k;
		for (int i = 0; i < n; i++) begin
			r        = random_req();
			r.mode   = OP_ADD;
			k.mask   = {ADDR_W{1'b1}} << (32 - $urandom_range(8, 32));
			k.prefix = ADDR_W'($urandom) & k.mask;
			r.mask   = k.mask;
			r.address = k.prefix;
			if (key_pool.size() < DEPTH)
				key_pool.insert(key_pool.size(), k);
			pending_reqs.insert(pending_reqs.size(), r);
			if (i % 4 == 3) begin
				r         = random_req();
				k         = key_pool[$urandom_range(0, key_pool.size() - 1)];
				r.address = k.prefix | ($urandom & ~k.mask);
				pending_reqs.insert(pending_reqs.size(), r);
			end
		end
	endtask

	task automatic gen_drain();
		route_req_t r;
		route_key_t k;
		while (key_pool.size() > 0) begin
			k         = key_pool.pop_front();
			r         = random_req();
			r.mode    = OP_REMOVE;
			r.mask    = k.mask;
			r.address = k.prefix | ($urandom & ~k.mask);
			pending_reqs.insert(pending_reqs.size(), r);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			offer    = s_tvalid && !in_taken;
			in_taken = 1'b0;
			if (!offer && pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
				cur_req = pending_reqs.pop_front();
				s_tdata <= {1'b0, cur_req.replace_ok, cur_req.egress_port, cur_req.gateway,
					cur_req.mask, cur_req.address, cur_req.mode};
				offer   = 1'b1;
			end
			s_tvalid <= offer;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 300) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || $urandom_range(0, 99) >= 14;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (s_tvalid && s_tready) begin
				want = route_table_step(cur_req);
				status_count[want.status] = status_count[want.status] + 1;
				expected_resp.insert(expected_resp.size(), want);
				in_taken    = 1'b1;
				items_taken = items_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				results_seen = results_seen + 1;
				if (expected_resp.size() == 0) begin
					$error("result item arrived with no expectation pending");
					fail_count = fail_count + 1;
				end else begin
					want = expected_resp.pop_front();
					if (m_tdata[2:0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[34:3] !== want.next_hop) begin
						$error("next_hop: expected %h, got %h", want.next_hop, m_tdata[34:3]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[38:35] !== want.route_port) begin
						$error("route_port: expected %0d, got %0d", want.route_port, m_tdata[38:35]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[70:39] !== want.prev_gw) begin
						$error("previous_gateway: expected %h, got %h", want.prev_gw, m_tdata[70:39]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[74:71] !== want.prev_port) begin
						$error("previous_port: expected %0d, got %0d", want.prev_port,
							m_tdata[74:71]);
						fail_count = fail_count + 1;
					end
				end
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("tb_linear_prefix_route_table failed");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		in_taken     = 1'b0;
		items_taken  = 0;
		results_seen = 0;
		fail_count   = 0;
		idle_cycles  = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		for (int i = 0; i < 5; i++)
			status_count[i] = 0;
		for (int i = 0; i < DEPTH; i++)
			slot_valid[i] = 1'b0;
		for (int i = 0; i < 8; i++)
			route_bases[i] = $urandom;

		// Empty table, unused mode, default route, bits outside the mask, exists and replace,
		// host route, a non-contiguous mask and removal of present and absent routes.
		push_req(OP_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1);
		push_req(OP_REMOVE, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0, 4'h0, 1'b0);
		push_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1);
		push_req(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0, 4'h0, 1'b0);
		push_req(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_ADD, 32'h0AFF_FFFF, 32'hFF00_0000, 32'hFFFF_FFFF, 4'hF, 1'b0);
		push_req(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0001, 4'h3, 1'b0);
		push_req(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'h5, 1'b1);
		push_req(OP_LOOKUP, 32'h0A7F_0000, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_ADD, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0, 4'h9, 1'b0);
		push_req(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_ADD, 32'h0A01_0203, 32'hFF00_FF00, 32'hC0A8_0001, 4'h7, 1'b0);
		push_req(OP_LOOKUP, 32'h0A55_0211, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_REMOVE, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0, 4'h0, 1'b0);
		push_req(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0, 4'h0, 1'b0);
		push_req(OP_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 4'h0, 1'b0);
		push_req(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0, 4'h0, 1'b0);
		push_req(OP_REMOVE, 32'h0A12_3456, 32'hFF00_0000, 32'h0, 4'h0, 1'b0);
		push_req(OP_REMOVE, 32'h0A00_0200, 32'hFF00_FF00, 32'h0, 4'h0, 1'b0);
		push_req(OP_LOOKUP, 32'h0A55_0211, 32'h0, 32'h0, 4'h0, 1'b0);

		gen_mixed(520);
		gen_fill(80);
		gen_mixed(150);
		gen_drain();
		gen_mixed(ITEM_TARGET - pending_reqs.size());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || expected_resp.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);

		$display("Ran %0d table operations: %0d ok, %0d no route, %0d exists, %0d not found, %0d full.",
			items_taken, status_count[STAT_OK], status_count[STAT_NO_ROUTE],
			status_count[STAT_EXISTS], status_count[STAT_NOT_FOUND], status_count[STAT_FULL]);
		$display("Checked %0d results, with one %0d-cycle receiver stall; %0d mismatches.",
			results_seen, HOLD_CYCLES, fail_count);
		if (fail_count == 0 && expected_resp.size() == 0)
			$display("tb_linear_prefix_route_table passed");
		else
			$display("tb_linear_prefix_route_table failed");
		$finish;
	end

endmodule
